// ----- rtl/vfd_pkg.sv -----
// ----------------------------------------------------------------------------
// vfd_pkg
// Shared types and constants for the vision frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package vfd_pkg;

  // Byte and bus widths
  localparam int unsigned ByteW    = 8;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 64;
  localparam int unsigned WordW    = 16;

  // Frame delimiters
  localparam logic [ByteW-1:0] HeaderByte = 8'h5A;
  localparam logic [ByteW-1:0] TailByte   = 8'hA5;

  // Only frame bytes 1 to 8 feed the decoded result
  localparam int unsigned StoreFirst = 1;
  localparam int unsigned StoreDepth = 8;
  localparam int unsigned StoreIdxW  = 3;

  // Bit positions inside frame byte 1
  localparam int unsigned PresentBit = 7;
  localparam int unsigned KindBit    = 6;

  // One decoded frame
  typedef struct packed {
    logic [WordW-1:0] pixel_velocity;
    logic [WordW-1:0] target_y;
    logic [WordW-1:0] target_x;
    logic [ByteW-1:0] target_distance;
    logic             target_kind;
    logic             target_present;
  } result_t;

  // Parser handshake toward the output register
  typedef struct packed {
    logic step;   // a byte is consumed this cycle
    logic done;   // that byte completes a frame
  } parse_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/vision_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// vision_frame_deframer
// Parses received serial bytes into fixed-length frames (0x5A header,
// 0xA5 tail) and emits one decoded target record per complete frame.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Transaction           Payload
//  s_axis    in   one received byte     tdata[7:0] rx_byte
//  m_axis    out  one decoded frame     tdata[57:0] target fields, [63:58] zero
//
//  One byte per cycle sustained while the result register is free; the
//  tail byte passes the input register, then the result register, before
//  m_axis_tvalid rises. Parse state updates from the registered byte.
//  Reset clears frame state and both valid flags; no clearing pass.
//  A stalled result register holds the input register, which then drops
//  tready; one byte of slack parts the two sides.
// ----------------------------------------------------------------------------
`default_nettype none

module vision_frame_deframer #(
  parameter int unsigned FRAME_LENGTH = 10
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output      logic                         s_axis_tready,
  input  wire logic [vfd_pkg::InDataW-1:0]  s_axis_tdata,   // [7:0] rx_byte
  output      logic                         m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // [0] target_present, [1] target_kind, [9:2] target_distance,
  // [25:10] target_x, [41:26] target_y, [57:42] pixel_velocity, [63:58] zero
  output      logic [vfd_pkg::OutDataW-1:0] m_axis_tdata
);
  import vfd_pkg::*;

  logic             byte_valid;
  logic [ByteW-1:0] byte_val;
  logic             out_free;
  logic             step;
  parse_ctrl_t      ctrl;
  result_t          result;

  // Consume the held byte whenever the result register can take a result
  assign step = byte_valid && out_free;

  vfd_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata[ByteW-1:0]),
    .consume_i  (step),
    .valid_o    (byte_valid),
    .byte_o     (byte_val)
  );

  vfd_parser #(
    .FRAME_LENGTH (FRAME_LENGTH)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (byte_val),
    .ctrl_o   (ctrl),
    .result_o (result)
  );

  vfd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .result_i    (result),
    .free_o      (out_free),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ----- rtl/vfd_in_reg.sv -----
// ----------------------------------------------------------------------------
// vfd_in_reg
// Input register: holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module vfd_in_reg (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output      logic                       in_ready_o,
  input  wire logic [vfd_pkg::ByteW-1:0]  in_byte_i,
  input  wire logic                       consume_i,
  output      logic                       valid_o,
  output      logic [vfd_pkg::ByteW-1:0]  byte_o
);
  import vfd_pkg::*;

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q;
  logic             load;

  // Room when empty or when the held byte leaves this cycle
  assign in_ready_o = !valid_q || consume_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (consume_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= in_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

`default_nettype wire

// ----- rtl/vfd_parser.sv -----
// ----------------------------------------------------------------------------
// vfd_parser
// Frame state, byte store, field decode; one byte per cycle on step_i.
// ----------------------------------------------------------------------------
`default_nettype none

module vfd_parser #(
  parameter int unsigned FRAME_LENGTH = 10
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      step_i,
  input  wire logic [vfd_pkg::ByteW-1:0] byte_i,
  output      vfd_pkg::parse_ctrl_t      ctrl_o,
  output      vfd_pkg::result_t          result_o
);
  import vfd_pkg::*;

  localparam int unsigned PosW = $clog2(FRAME_LENGTH + 1);
  localparam logic [PosW-1:0] PosFull = PosW'(FRAME_LENGTH);
  localparam logic [PosW-1:0] PosLast = PosW'(FRAME_LENGTH - 1);
  localparam logic [PosW-1:0] PosLo   = PosW'(StoreFirst);
  localparam logic [PosW-1:0] PosHi   = PosW'(StoreFirst + StoreDepth - 1);

  logic            in_frame_q, in_frame_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [ByteW-1:0] store_q [StoreDepth];
  logic            done;
  logic            wr_en;
  logic [PosW-1:0] pos_off;
  logic [StoreIdxW-1:0] wr_idx;

  // Next state for the consumed byte
  always_comb begin
    in_frame_d = in_frame_q;
    pos_d      = pos_q;
    done       = 1'b0;
    wr_en      = 1'b0;
    if (step_i) begin
      if (!in_frame_q) begin
        // Header opens a frame; it sits at position 0 and is not kept
        if (byte_i == HeaderByte) begin
          in_frame_d = 1'b1;
          pos_d      = PosW'(1);
        end
      end else if (pos_q == PosFull) begin
        // Full frame without tail: this byte aborts it
        in_frame_d = 1'b0;
        pos_d      = '0;
      end else begin
        wr_en = 1'b1;
        if (byte_i == TailByte) begin
          done       = (pos_q == PosLast);
          in_frame_d = 1'b0;
          pos_d      = '0;
        end else begin
          pos_d = pos_q + PosW'(1);
        end
      end
    end
  end

  assign pos_off = pos_q - PosLo;
  assign wr_idx  = pos_off[StoreIdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      pos_q      <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      pos_q      <= pos_d;
    end
  end

  // Byte store for frame bytes 1 to 8
  always_ff @(posedge clk_i) begin
    if (wr_en && (pos_q >= PosLo) && (pos_q <= PosHi)) begin
      store_q[wr_idx] <= byte_i;
    end
  end

  // Decode from stored bytes
  always_comb begin
    result_o.target_present  = store_q[0][PresentBit];
    result_o.target_kind     = store_q[0][KindBit];
    result_o.target_distance = store_q[1];
    result_o.target_x        = {store_q[2], store_q[3]};
    result_o.target_y        = {store_q[4], store_q[5]};
    result_o.pixel_velocity  = {store_q[6], store_q[7]};
  end

  assign ctrl_o.step = step_i;
  assign ctrl_o.done = done;

  // Checks
  a_pos_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosFull) else $error("byte position beyond frame length");

  a_idle_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_frame_q |-> pos_q == '0) else $error("position nonzero while idle");

  a_done_closes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> !in_frame_q && pos_q == '0)
    else $error("frame still open after completion");

  a_done_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> in_frame_q && pos_q == PosLast)
    else $error("completion at wrong position");

endmodule

`default_nettype wire

// ----- rtl/vfd_out_reg.sv -----
// ----------------------------------------------------------------------------
// vfd_out_reg
// Result register: holds one decoded frame until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module vfd_out_reg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire vfd_pkg::parse_ctrl_t         ctrl_i,
  input  wire vfd_pkg::result_t             result_i,
  output      logic                         free_o,
  output      logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  output      logic [vfd_pkg::OutDataW-1:0] out_data_o
);
  import vfd_pkg::*;

  logic    valid_q, valid_d;
  result_t data_q;
  logic    load;

  // Free when empty or when the held result is taken this cycle
  assign free_o = !valid_q || out_ready_i;
  assign load   = ctrl_i.step && ctrl_i.done;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = {(OutDataW - $bits(result_t))'(0), data_q};

  // Checks
  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> free_o) else $error("result loaded over a pending result");

  a_load_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> valid_q) else $error("loaded result not presented");

  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !out_ready_i |=> valid_q && $stable(data_q))
    else $error("pending result lost");

endmodule

`default_nettype wire
